### design/base32_stream_encoder_core_macros.svh
// Assertion helpers shared by the encoder RTL.
// Each one expects signals named clock and reset in the using module.
`ifndef BASE32_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE32_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication.
`define B32E_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define B32E_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/b32e_pkg.sv
`default_nettype none

package b32e_pkg;

   localparam int unsigned GroupBits  = 5;
   localparam int unsigned MaxGroups  = 3;
   localparam int unsigned LeftBits   = 4;
   localparam logic [4:0]  GroupMask  = 5'h1F;
   localparam logic [4:0]  DigitBase  = 5'd26;
   localparam logic [6:0]  AsciiUpperA = 7'h41;
   localparam logic [6:0]  AsciiTwo   = 7'h32;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_item_type;

   typedef struct packed {
      logic [6:0] symbol;
      logic       last_symbol;
   } rsp_item_type;

   // One byte's worth of work: up to three 5-bit groups, in output order.
   typedef struct packed {
      logic [MaxGroups-1:0][GroupBits-1:0] groups;
      logic [1:0]                          count;
      logic                                eom;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Alphabet: A-Z for 0..25, 2-7 for 26..31.
   function automatic logic [6:0] b32e_symbol(input logic [4:0] value);
      logic [4:0] v;
      v = value & GroupMask;
      if (v < DigitBase) begin
         return AsciiUpperA + {2'b00, v};
      end else begin
         return AsciiTwo + {2'b00, v - DigitBase};
      end
   endfunction

endpackage

`default_nettype wire

### design/base32_stream_encoder_core.sv
// Base32 stream encoder (standard alphabet A-Z, 2-7, no '=' padding).
// req channel: one data byte per transfer, end_of_message set on the final
//   byte of a message. rsp channel: one ASCII symbol per transfer,
//   last_symbol set on the final symbol of that message.
// Each byte yields one or two symbols; the final byte may add a flush symbol
//   for leftover bits, zero-filled on the right.
// A byte reaches rsp through the job queue and then the output register: it
//   lands in the queue on its req transfer, and the output register loads
//   its first symbol once the job reaches the queue head.
// Throughput: one symbol per cycle on rsp while the queue holds jobs and
//   rsp_stall is low; the back-end symbol sequencer and its output
//   register set this rate.
// A job queue (QUEUE_DEPTH entries) sits between the byte front end and the
//   symbol back end; req_stall rises only when that queue is full, so bytes
//   keep flowing while rsp is briefly stalled.
// rsp_stall holds the output register and its payload; the back end then
//   stops draining and the queue fills up.
// Reset (synchronous) clears the bit accumulator, the queue and the output
//   valid; req_stall is low after reset, so the block can take a byte.
`default_nettype none

module base32_stream_encoder_core
   import b32e_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_payload
);

   job_type          front_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             take;
   logic             pop;

   // byte transfer completes only when the queue has room
   assign req_stall = q_status.full;
   assign take      = req_valid && !q_status.full;

   // front: splits the byte into 5-bit groups against the carried bits
   b32e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_payload (req_payload),
      .job         (front_job)
   );

   b32e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_job (front_job),
      .pop      (pop),
      .head     (head_job),
      .status   (q_status)
   );

   // back: walks head job groups, one symbol per cycle while not stalled
   b32e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_job),
      .status      (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### design/b32e_front.sv
`default_nettype none

module b32e_front
   import b32e_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire req_item_type req_payload,
   output job_type           job
);

   logic [LeftBits-1:0] acc_ff, acc_in;
   logic [2:0]          pend_ff, pend_in;

   logic [2:0]  n;
   logic [4:0]  mask_n;
   logic [3:0]  acc_m;
   logic [11:0] window;
   logic [3:0]  total;
   logic        two;
   logic [4:0]  g0, g1;
   logic [2:0]  rem;
   logic [4:0]  mask_r;
   logic [3:0]  remv;
   logic [4:0]  flushv;
   logic        flush;

   always_comb begin
      n      = (pend_ff > 3'd4) ? 3'd4 : pend_ff;
      mask_n = (5'd1 << n) - 5'd1;
      acc_m  = acc_ff & mask_n[3:0];
      window = {acc_m, req_payload.data_byte};
      total  = {1'b0, n} + 4'd8;
      two    = (total >= 4'd10);
      g0     = 5'(window >> (total - 4'd5));
      g1     = 5'(window >> (total - 4'd10));
      rem    = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
      mask_r = (5'd1 << rem) - 5'd1;
      remv   = window[3:0] & mask_r[3:0];
      flushv = 5'({1'b0, remv} << (3'd5 - rem));
      flush  = req_payload.end_of_message && (rem != 3'd0);

      job.groups[0] = g0;
      job.groups[1] = two ? g1 : flushv;
      job.groups[2] = flushv;
      job.count     = (two ? 2'd2 : 2'd1) + {1'b0, flush};
      job.eom       = req_payload.end_of_message;

      acc_in  = acc_ff;
      pend_in = pend_ff;
      if (take) begin
         acc_in  = req_payload.end_of_message ? '0 : remv;
         pend_in = req_payload.end_of_message ? '0 : rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

### design/b32e_queue.sv
`default_nettype none

module b32e_queue
   import b32e_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire job_type    push_job,
   input  wire logic       pop,
   output job_type         head,
   output queue_status_type status
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   job_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   always_comb begin
      status.full  = (cnt_ff == FullCnt);
      status.empty = (cnt_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = mem_ff[rd_ff];
      wr_in  = do_push ? ((wr_ff == LastPtr) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LastPtr) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### design/b32e_back.sv
`default_nettype none

`include "base32_stream_encoder_core_macros.svh"

module b32e_back
   import b32e_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          head,
   input  wire queue_status_type status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_item_type          rsp_payload
);

   logic [1:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   rsp_item_type data_ff, data_in;
   logic         load, fire, at_end;

   always_comb begin
      load   = !valid_ff || !rsp_stall;
      fire   = load && !status.empty;
      at_end = (idx_ff == head.count - 2'd1);
      pop    = fire && at_end;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = fire;
      end
      if (fire) begin
         idx_in              = at_end ? 2'd0 : idx_ff + 2'd1;
         data_in.symbol      = b32e_symbol(head.groups[idx_ff]);
         data_in.last_symbol = head.eom && at_end;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   `B32E_ASSERT_NOW(a_idx_in_job, !status.empty, idx_ff < head.count, "group index past job")
   `B32E_ASSERT_NOW(a_idx_idle, status.empty, idx_ff == 2'd0, "group index left mid-job")
   `B32E_ASSERT_NEXT(a_sym_range, fire, (data_ff.symbol >= 7'd50) && (data_ff.symbol <= 7'd90), "symbol outside alphabet")

endmodule

`default_nettype wire

### tb/sv/base32_stream_encoder_core_tb.sv
`default_nettype none

module base32_stream_encoder_core_tb;
   import b32e_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Run shape
   localparam int unsigned RandomBytes = 410;
   localparam int unsigned TailItems   = 60;     // no idling on either side here
   localparam int unsigned HoldAt      = 150;    // bytes accepted before the long rsp hold-off
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned DrainAt     = 260;    // random byte index that waits for a drain
   localparam int unsigned SettleCycles = 20;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned MaxReports  = 10;

   // Alphabet anchors: values 0..25 map onto letters, 26..31 onto digits 2..7
   localparam logic [6:0]  CharA       = 7'h41;
   localparam logic [6:0]  CharTwo     = 7'h32;
   localparam logic [4:0]  LetterCount = 5'd26;
   localparam int unsigned SymbolBits  = 5;

   typedef struct {
      req_item_type item;
      int unsigned  gap;          // idle cycles before the byte is offered
      bit           drain_first;  // hold the byte back until every symbol is out
   } byte_entry_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_payload;

   base32_stream_encoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Stimulus and expectations
   byte_entry_type byte_queue[$];
   rsp_item_type   expected_symbols[$];
   bit             stim_ready = 1'b0;

   // Predictor state: leftover bits (low pend_count positions) of the current message
   logic [3:0]   pend_acc   = '0;
   logic [2:0]   pend_count = '0;

   int unsigned  mismatches     = 0;
   int unsigned  bytes_accepted = 0;
   int unsigned  cycle_count    = 0;
   bit           req_taken      = 1'b0;   // transfer on req at the last rising edge
   rsp_item_type want;

   function automatic logic [6:0] to_ascii(input logic [4:0] value);
      if (value < LetterCount) begin
         return CharA + {2'b00, value};
      end else begin
         return CharTwo + {2'b00, value - LetterCount};
      end
   endfunction

   // Appends the symbols one byte produces and advances the leftover bits.
   task automatic encode_byte(input req_item_type item);
      logic [11:0]  acc;
      int unsigned  n;
      rsp_item_type sym;
      acc = {pend_acc, item.data_byte};
      n   = pend_count + 8;
      while (n >= SymbolBits) begin
         n = n - SymbolBits;
         sym.symbol      = to_ascii(5'(acc >> n));
         sym.last_symbol = 1'b0;
         expected_symbols = {expected_symbols, sym};
      end
      acc = acc & ((12'd1 << n) - 12'd1);
      if (item.end_of_message) begin
         if (n > 0) begin
            // leftover bits flushed, zero-filled on the right
            sym.symbol      = to_ascii(5'(acc << (SymbolBits - n)));
            sym.last_symbol = 1'b1;
            expected_symbols = {expected_symbols, sym};
         end else begin
            // byte boundary lands on a group boundary: no flush symbol
            expected_symbols[expected_symbols.size() - 1].last_symbol = 1'b1;
         end
         pend_acc   = '0;
         pend_count = '0;
      end else begin
         pend_acc   = acc[3:0];
         pend_count = 3'(n);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                  input logic [7:0] act_v);
      mismatches++;
      if (mismatches <= MaxReports) begin
         $display("mismatch (%s): expected %h, got %h", what, exp_v, act_v);
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input logic eom, input int unsigned gap,
                            input bit drain_first);
      byte_entry_type e;
      e.item.data_byte      = data;
      e.item.end_of_message = eom;
      e.gap                 = gap;
      e.drain_first         = drain_first;
      byte_queue = {byte_queue, e};
   endtask

   function automatic int unsigned pick_gap(input bit quiet);
      if (quiet || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 10);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Monitor: both channels sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            encode_byte(req_payload);
            bytes_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch("symbol with nothing expected", 8'h00,
                               {1'b0, rsp_payload.symbol});
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_payload.symbol !== want.symbol) begin
                  report_mismatch("symbol", {1'b0, want.symbol}, {1'b0, rsp_payload.symbol});
               end
               if (rsp_payload.last_symbol !== want.last_symbol) begin
                  report_mismatch("last_symbol", {7'd0, want.last_symbol},
                                  {7'd0, rsp_payload.last_symbol});
               end
            end
         end
      end
   end

   // Driver: req side changes at the falling edge; a pending transfer holds its payload.
   byte_entry_type cur;
   bit             have_cur = 1'b0;
   int unsigned    gap_left = 0;

   always @(negedge clock) begin
      if (!reset && stim_ready && !(req_valid && !req_taken)) begin
         if (!have_cur && byte_queue.size() > 0) begin
            cur      = byte_queue.pop_front();
            have_cur = 1'b1;
            gap_left = cur.gap;
         end
         if (!have_cur) begin
            req_valid <= 1'b0;
         end else if (cur.drain_first && expected_symbols.size() != 0) begin
            // sender pause: wait until every symbol so far has been taken
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_payload <= cur.item;
            have_cur     = 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, quiet stretches, one long hold-off, none in the tail.
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   int unsigned burst_left = 0;
   int unsigned quiet_left = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && bytes_accepted >= HoldAt) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            // queue behind rsp fills up and req_stall has to rise
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stim_ready && byte_queue.size() < TailItems) begin
            rsp_stall <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(10, 40);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus build, reset, end of run
   initial begin : main
      int unsigned count;
      int unsigned len;
      int unsigned quiet_run;
      int unsigned i;
      bit          quiet;

      // Directed messages: leftovers of 3, 3, 1, 4, 2 and 0 bits at the end mark
      push_byte(8'h00, 1'b1, 0, 1'b0);
      push_byte(8'hFF, 1'b1, pick_gap(1'b0), 1'b0);
      push_byte(8'hFF, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'hFF, 1'b1, pick_gap(1'b0), 1'b0);
      push_byte(8'h00, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'hFF, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h7C, 1'b1, pick_gap(1'b0), 1'b0);
      // four bytes: last one yields two groups plus a flush symbol
      push_byte(8'h01, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h02, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h04, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h08, 1'b1, pick_gap(1'b0), 1'b0);
      // five bytes end exactly on a group boundary: no flush symbol
      push_byte(8'hFF, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h00, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'hA5, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h5A, 1'b0, pick_gap(1'b0), 1'b0);
      push_byte(8'h80, 1'b1, pick_gap(1'b0), 1'b0);
      // all-ones across a full 40-bit block
      for (i = 0; i < 5; i++) begin
         push_byte(8'hFF, (i == 4), pick_gap(1'b0), 1'b0);
      end

      // Random messages; mostly short, a few long
      count     = 0;
      quiet_run = 0;
      while (count < RandomBytes) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         for (i = 0; i < len; i++) begin
            if (quiet_run > 0) begin
               quiet_run--;
            end else if ($urandom_range(0, 29) == 0) begin
               quiet_run = $urandom_range(10, 30);
            end
            quiet = (quiet_run > 0);
            push_byte(pick_byte(), (i == len - 1), pick_gap(quiet),
                      (count == 0) || (count == DrainAt));
            count++;
         end
      end
      for (i = byte_queue.size() - TailItems; i < byte_queue.size(); i++) begin
         byte_queue[i].gap = 0;
      end
      stim_ready = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every byte transferred, then every symbol out
      while (byte_queue.size() != 0 || have_cur || req_valid) begin
         @(posedge clock);
      end
      while (expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      if (expected_symbols.size() != 0) begin
         report_mismatch("symbols never produced", 8'(expected_symbols.size()), 8'h00);
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
